@@ design/rmf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the 5x5 RGB median filter: shared widths, constants and types.
// Used by rmf_front, rmf_queue, rmf_median, the top level and the testbench; depends on nothing.
package rmf_pkg;

    localparam int CHANNELS    = 3;
    localparam int CH_W        = 8;
    localparam int PIX_W       = CHANNELS * CH_W;
    localparam int WINDOW      = 5;
    localparam int LAG         = WINDOW - 1;
    localparam int WIN_AREA    = WINDOW * WINDOW;
    localparam int MEDIAN_RANK = WIN_AREA / 2;
    localparam int RANK_W      = $clog2(WIN_AREA + 1);
    localparam int LB_ROWS     = WINDOW - 1;
    localparam int LB_W        = LB_ROWS * PIX_W;
    localparam int MAX_PW      = 2048;
    localparam int LB_ADDR_W   = $clog2(MAX_PW);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OW_W        = 11;
    localparam int OH_W        = 13;
    localparam int PW_W        = 12;
    localparam int ROW_W       = OH_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 2'd2;

    localparam logic [OW_W-1:0] OUT_WIDTH_RST    = 11'd640;
    localparam logic [OH_W-1:0] OUT_HEIGHT_RST   = 13'd480;
    localparam logic [PW_W-1:0] PADDED_WIDTH_RST = 12'd644;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WIN_AREA-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t win;
        logic last;
    } win_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

@@ design/rmf_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/rmf_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, row/column counters, line buffers and
// the sliding 5x5 window. Depends on rmf_pkg and rmf_ram.
module rmf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rmf_pkg::CH_W-1:0]      pixel_c0,
    input  logic [rmf_pkg::CH_W-1:0]      pixel_c1,
    input  logic [rmf_pkg::CH_W-1:0]      pixel_c2,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  rmf_pkg::q_status_t            q_stat,
    output logic                          q_push,
    output rmf_pkg::win_item_t            q_item
);
    import rmf_pkg::*;

    logic [OW_W-1:0]      out_width_reg;
    logic [OH_W-1:0]      out_height_reg;
    logic [PW_W-1:0]      padded_width_reg;
    logic [LB_ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [PW_W-1:0]      pw_eff;
    logic [ROW_W-1:0]     rows;
    logic [LB_ADDR_W-1:0] c_adj;
    logic [ROW_W-1:0]     r_adj, r_inc;
    logic [PW_W-1:0]      c_inc, lastc;
    logic                 accept, emit, last;

    logic                 s1_valid_reg, s1_emit_reg, s1_last_reg;
    pix_t                 s1_pix_reg;
    logic [LB_ADDR_W-1:0] s1_addr_reg;
    logic                 byp_valid_reg;
    logic [LB_W-1:0]      byp_data_reg;
    logic [LB_W-1:0]      rd_data, lb_old, lb_wr_data;
    win_t                 win_reg, win_next;
    logic [QCNT_W:0]      room_need;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg    <= OUT_WIDTH_RST;
            out_height_reg   <= OUT_HEIGHT_RST;
            padded_width_reg <= PADDED_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OUT_WIDTH:    out_width_reg    <= cfg_data[OW_W-1:0];
                CFG_OUT_HEIGHT:   out_height_reg   <= cfg_data[OH_W-1:0];
                CFG_PADDED_WIDTH: padded_width_reg <= cfg_data[PW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Every accepted pixel may end up in the queue in the following cycle.
    assign room_need   = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(s1_valid_reg);
    assign pixel_ready = room_need < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept      = pixel_valid && pixel_ready;

    always_comb
    begin
        if (padded_width_reg > PW_W'(MAX_PW))
        begin
            pw_eff = PW_W'(MAX_PW);
        end
        else if (padded_width_reg == '0)
        begin
            pw_eff = PW_W'(1);
        end
        else
        begin
            pw_eff = padded_width_reg;
        end
        rows  = ROW_W'(out_height_reg) + ROW_W'(LAG);
        c_adj = (PW_W'(col_reg) >= pw_eff) ? '0 : col_reg;
        r_adj = (row_reg >= rows) ? '0 : row_reg;
        emit  = (r_adj >= ROW_W'(LAG)) && (c_adj >= LB_ADDR_W'(LAG))
                && (PW_W'(c_adj) < PW_W'(out_width_reg) + PW_W'(LAG));
        lastc = PW_W'(out_width_reg) + PW_W'(LAG - 1);
        if (lastc > pw_eff - PW_W'(1))
        begin
            lastc = pw_eff - PW_W'(1);
        end
        last  = emit && (r_adj == rows - ROW_W'(1)) && (PW_W'(c_adj) == lastc);
        c_inc = PW_W'(c_adj) + PW_W'(1);
        r_inc = r_adj + ROW_W'(1);
        if (c_inc >= pw_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= rows) ? '0 : r_inc;
        end
        else
        begin
            col_next = c_inc[LB_ADDR_W-1:0];
            row_next = r_adj;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            byp_valid_reg <= accept && s1_valid_reg && (c_adj == s1_addr_reg);
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= lb_wr_data;
        if (accept)
        begin
            s1_pix_reg  <= {pixel_c2, pixel_c1, pixel_c0};
            s1_addr_reg <= c_adj;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
        end
        if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    rmf_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_PW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr_data),
        .rd_en   (accept),
        .rd_addr (c_adj),
        .rd_data (rd_data)
    );

    // A read of the column written in the same cycle takes the new word.
    assign lb_old     = byp_valid_reg ? byp_data_reg : rd_data;
    assign lb_wr_data = {lb_old[LB_W-PIX_W-1:0], s1_pix_reg};

    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            for (int k = 0; k < WINDOW - 1; k++)
            begin
                win_next[i*WINDOW+k] = win_reg[i*WINDOW+k+1];
            end
            if (i < LB_ROWS)
            begin
                win_next[i*WINDOW+WINDOW-1] = lb_old[(LB_ROWS-1-i)*PIX_W +: PIX_W];
            end
            else
            begin
                win_next[i*WINDOW+WINDOW-1] = s1_pix_reg;
            end
        end
    end

    assign q_push      = s1_valid_reg && s1_emit_reg;
    assign q_item.win  = win_next;
    assign q_item.last = s1_last_reg;

    a_bypass_addr: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> ($past(s1_valid_reg) && $past(accept)))
        else $error("bypass without back-to-back write");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
        else $error("window pushed into a full queue");
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_emit_reg)
        else $error("frame end on a pixel with no result");

endmodule

@@ design/rmf_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of finished windows between the front end and the median unit.
// Depends on rmf_pkg.
module rmf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rmf_pkg::win_item_t push_item,
    input  logic               pop,
    output rmf_pkg::win_item_t head_item,
    output rmf_pkg::q_status_t stat
);
    import rmf_pkg::*;

    win_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ design/rmf_median.sv @@
`timescale 1ns / 1ps
// Back end: three-stage rank network that picks the 13th smallest of 25 per
// component, with the output register. Depends on rmf_pkg.
module rmf_median (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rmf_pkg::q_status_t       q_stat,
    input  rmf_pkg::win_item_t       head_item,
    output logic                     q_pop,
    output logic [rmf_pkg::CH_W-1:0] med_c0,
    output logic [rmf_pkg::CH_W-1:0] med_c1,
    output logic [rmf_pkg::CH_W-1:0] med_c2,
    output logic                     frame_last,
    output logic                     med_valid,
    input  logic                     med_ready
);
    import rmf_pkg::*;

    typedef logic [WIN_AREA-1:0] bits_t;

    logic                   en;
    bits_t                  lt_c [CHANNELS][WIN_AREA];
    bits_t                  lt_reg [CHANNELS][WIN_AREA];
    bits_t                  sel_c [CHANNELS];
    bits_t                  sel_reg [CHANNELS];
    win_t                   a_win_reg, b_win_reg;
    logic                   a_valid_reg, b_valid_reg, out_valid_reg;
    logic                   a_last_reg, b_last_reg, out_last_reg;
    logic [CH_W-1:0]        med_c [CHANNELS];
    logic [CH_W-1:0]        med_reg [CHANNELS];
    logic [RANK_W-1:0]      rank;

    assign en    = !out_valid_reg || med_ready;
    assign q_pop = en && (q_stat.count != '0);

    // Element j counts against element i when it is smaller, or equal with
    // a lower index, so every window has exactly one element of each rank.
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int i = 0; i < WIN_AREA; i++)
            begin
                for (int j = 0; j < WIN_AREA; j++)
                begin
                    lt_c[ch][i][j] = (j != i) &&
                        ((head_item.win[j][ch*CH_W +: CH_W] <
                          head_item.win[i][ch*CH_W +: CH_W]) ||
                         ((head_item.win[j][ch*CH_W +: CH_W] ==
                           head_item.win[i][ch*CH_W +: CH_W]) && (j < i)));
                end
            end
        end
    end

    always_comb
    begin
        rank = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int i = 0; i < WIN_AREA; i++)
            begin
                rank = RANK_W'($countones(lt_reg[ch][i]));
                sel_c[ch][i] = (rank == RANK_W'(MEDIAN_RANK));
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            med_c[ch] = '0;
            for (int i = 0; i < WIN_AREA; i++)
            begin
                med_c[ch] = med_c[ch] |
                    (b_win_reg[i][ch*CH_W +: CH_W] & {CH_W{sel_reg[ch][i]}});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= q_pop;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_win_reg    <= head_item.win;
            a_last_reg   <= head_item.last;
            lt_reg       <= lt_c;
            b_win_reg    <= a_win_reg;
            b_last_reg   <= a_last_reg;
            sel_reg      <= sel_c;
            med_reg      <= med_c;
            out_last_reg <= b_last_reg;
        end
    end

    assign med_valid  = out_valid_reg;
    assign med_c0     = med_reg[0];
    assign med_c1     = med_reg[1];
    assign med_c2     = med_reg[2];
    assign frame_last = out_last_reg;

    a_sel_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> ($onehot(sel_reg[0]) && $onehot(sel_reg[1])
                         && $onehot(sel_reg[2])))
        else $error("median select is not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !med_ready) |=> (out_valid_reg && $stable(med_reg[0])))
        else $error("stalled result changed");
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> en)
        else $error("queue popped while the pipeline is stalled");

endmodule

@@ design/rgb_median_filter_5x5.sv @@
`timescale 1ns / 1ps
// Top level of the 5x5 RGB median filter: front end, window queue, median unit.
// Depends on rmf_pkg, rmf_front, rmf_queue and rmf_median.
//
//  Channel   Direction  Handshake                  Payload
//  cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//  pixel     in         pixel_valid / pixel_ready  pixel_c0, pixel_c1, pixel_c2
//  med       out        med_valid / med_ready      med_c0..med_c2, frame_last
//
// One pixel request per clock is taken while pixel_ready is high; the line buffer RAM
// (read one cycle, written back the next) runs for each accepted pixel and the rank network
// once per cycle unless the output stalls. A pixel is registered in the front end, its
// window is queued, then three median stages follow, the first of which pops the queue.
// Reset clears counters, valid flags and queue pointers; line buffer and window are not cleared.
// A stalled output holds the median pipeline; the four-entry queue absorbs the front end
// until pixel_ready drops.
module rgb_median_filter_5x5 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [rmf_pkg::CH_W-1:0]       pixel_c0,
    input  logic [rmf_pkg::CH_W-1:0]       pixel_c1,
    input  logic [rmf_pkg::CH_W-1:0]       pixel_c2,
    output logic                           med_valid,
    input  logic                           med_ready,
    output logic [rmf_pkg::CH_W-1:0]       med_c0,
    output logic [rmf_pkg::CH_W-1:0]       med_c1,
    output logic [rmf_pkg::CH_W-1:0]       med_c2,
    output logic                           frame_last
);
    import rmf_pkg::*;

    q_status_t q_stat;
    win_item_t push_item, head_item;
    logic      q_push, q_pop;

    rmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_c0    (pixel_c0),
        .pixel_c1    (pixel_c1),
        .pixel_c2    (pixel_c2),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    rmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    rmf_median u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_item  (head_item),
        .q_pop      (q_pop),
        .med_c0     (med_c0),
        .med_c1     (med_c1),
        .med_c2     (med_c2),
        .frame_last (frame_last),
        .med_valid  (med_valid),
        .med_ready  (med_ready)
    );

endmodule

@@ sim/tb_rgb_median_filter_5x5.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_median_filter_5x5: frames and a partial row are streamed in,
// each median request is checked against a behavioral 5x5 window model.
// Depends on rmf_pkg and the block's RTL.
module tb_rgb_median_filter_5x5;
    import rmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PIXELS  = 200;
    localparam int PARTIAL_PIXELS = 40;

    typedef struct {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c2;
        logic            last;
    } med_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic [CH_W-1:0]       pixel_c0;
    logic [CH_W-1:0]       pixel_c1;
    logic [CH_W-1:0]       pixel_c2;
    logic                  med_valid;
    logic                  med_ready;
    logic [CH_W-1:0]       med_c0;
    logic [CH_W-1:0]       med_c1;
    logic [CH_W-1:0]       med_c2;
    logic                  frame_last;

    // Window model state.
    logic [PIX_W-1:0] line_mem[LB_ROWS][MAX_PW];
    logic [PIX_W-1:0] win_mem[WINDOW][WINDOW];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [OW_W-1:0]  m_out_width;
    logic [OH_W-1:0]  m_out_height;
    logic [PW_W-1:0]  m_padded_width;

    med_res_t pending_medians[$];
    int       error_count;
    int       pixels_sent;
    int       med_wait;
    int       idle_cycles;
    bit       no_gaps;
    bit       long_hold_req;

    rgb_median_filter_5x5 u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_c0    (pixel_c0),
        .pixel_c1    (pixel_c1),
        .pixel_c2    (pixel_c2),
        .med_valid   (med_valid),
        .med_ready   (med_ready),
        .med_c0      (med_c0),
        .med_c1      (med_c1),
        .med_c2      (med_c2),
        .frame_last  (frame_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [CH_W-1:0] rank_median(input logic [CH_W-1:0] vals[WIN_AREA]);
        logic [CH_W-1:0] sorted[WIN_AREA];
        logic [CH_W-1:0] x;
        int j;
        for (int i = 0; i < WIN_AREA; i++)
        begin
            x = vals[i];
            j = i;
            while (j > 0 && sorted[j-1] > x)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
        end
        return sorted[MEDIAN_RANK];
    endfunction

    function automatic int unsigned eff_padded_width(input int unsigned pw);
        if (pw > MAX_PW)
            return MAX_PW;
        if (pw == 0)
            return 1;
        return pw;
    endfunction

    // Advances the window model by one pixel and queues the median it produces, if any.
    function automatic void predict_medians(input logic [PIX_W-1:0] pix);
        int unsigned     pw;
        int unsigned     rows;
        int unsigned     c;
        int unsigned     r;
        int unsigned     lastc;
        bit              emit;
        logic [CH_W-1:0] vals[WIN_AREA];
        logic [CH_W-1:0] meds[CHANNELS];
        med_res_t        res;
        pw = eff_padded_width(m_padded_width);
        rows = m_out_height + LAG;
        c = col_pos;
        r = row_pos;
        if (c >= pw)
            c = 0;
        if (r >= rows)
            r = 0;
        for (int i = 0; i < WINDOW; i++)
            for (int k = 0; k < WINDOW - 1; k++)
                win_mem[i][k] = win_mem[i][k+1];
        for (int i = 0; i < WINDOW - 1; i++)
            win_mem[i][WINDOW-1] = line_mem[WINDOW-2-i][c];
        win_mem[WINDOW-1][WINDOW-1] = pix;
        for (int k = LB_ROWS - 1; k > 0; k--)
            line_mem[k][c] = line_mem[k-1][c];
        line_mem[0][c] = pix;

        emit = r >= LAG && c >= LAG && c < m_out_width + LAG;
        lastc = m_out_width + LAG - 1;
        if (lastc > pw - 1)
            lastc = pw - 1;
        if (c + 1 >= pw)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        if (emit)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int i = 0; i < WINDOW; i++)
                    for (int k = 0; k < WINDOW; k++)
                        vals[i*WINDOW+k] = win_mem[i][k][ch*CH_W +: CH_W];
                meds[ch] = rank_median(vals);
            end
            res.c0 = meds[0];
            res.c1 = meds[1];
            res.c2 = meds[2];
            res.last = r == rows - 1 && c == lastc;
            pending_medians.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    // Result side: ready is driven at the falling edge, results are checked at the rising edge.
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            med_wait = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (med_wait > 0)
        begin
            med_ready <= 1'b0;
            med_wait--;
        end
        else
            med_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        med_res_t want;
        if (rst_n && med_valid && med_ready)
        begin
            if (pending_medians.size() == 0)
                report_mismatch("unexpected result, no request pending", 1, 0);
            else
            begin
                want = pending_medians.pop_front();
                if (med_c0 !== want.c0)
                    report_mismatch("med_c0", med_c0, want.c0);
                if (med_c1 !== want.c1)
                    report_mismatch("med_c1", med_c1, want.c1);
                if (med_c2 !== want.c2)
                    report_mismatch("med_c2", med_c2, want.c2);
                if (frame_last !== want.last)
                    report_mismatch("frame_last", frame_last, want.last);
            end
            med_wait = no_gaps ? 0 : $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (med_valid && med_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] p0, input logic [CH_W-1:0] p1,
                              input logic [CH_W-1:0] p2);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_c0 <= p0;
        pixel_c1 <= p1;
        pixel_c2 <= p2;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        predict_medians({p2, p1, p0});
        pixels_sent++;
    endtask

    task automatic release_pixel_valid();
        @(negedge clk);
        pixel_valid <= 1'b0;
    endtask

    // Waits until every median has come back and the pipeline has drained.
    task automatic wait_idle();
        release_pixel_valid();
        wait (pending_medians.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OUT_WIDTH:    m_out_width = data[OW_W-1:0];
            CFG_OUT_HEIGHT:   m_out_height = data[OH_W-1:0];
            CFG_PADDED_WIDTH: m_padded_width = data[PW_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Unused high data bits are set at random; the register keeps only its own width.
    task automatic set_geometry(input int ow, input int oh, input int pw);
        logic [CFG_DATA_W-1:0] d;
        wait_idle();
        d = CFG_DATA_W'($urandom);
        d[OW_W-1:0] = OW_W'(ow);
        write_reg(CFG_OUT_WIDTH, d);
        write_reg(CFG_OUT_HEIGHT, CFG_DATA_W'(oh));
        d = CFG_DATA_W'($urandom);
        d[PW_W-1:0] = PW_W'(pw);
        write_reg(CFG_PADDED_WIDTH, d);
    endtask

    // Streams one whole extended frame; style 0 is uniform noise, 1 draws from few levels.
    task automatic send_frame(input int style);
        int n;
        logic [CH_W-1:0] lv[3];
        n = eff_padded_width(m_padded_width) * (m_out_height + LAG);
        lv = '{8'h00, 8'hFF, 8'($urandom)};
        for (int i = 0; i < n; i++)
        begin
            if (style == 0)
                send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            else
                send_pixel(lv[$urandom_range(0, 2)], lv[$urandom_range(0, 2)],
                           lv[$urandom_range(0, 2)]);
        end
    endtask

    // Smallest frame: one output pixel from 25 inputs with extreme and alternating values.
    task automatic test_single_output();
        logic [CH_W-1:0] pat[4];
        pat = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        set_geometry(1, 1, 5);
        for (int i = 0; i < WIN_AREA; i++)
            send_pixel(pat[i % 4], pat[(i + 1) % 4], pat[(i / 3) % 4]);
    endtask

    task automatic test_narrow_padding();
        set_geometry(10, 2, 8);
        send_frame(0);
    endtask

    task automatic test_empty_frames();
        set_geometry(0, 1, 5);
        send_frame(0);
        set_geometry(3, 0, 7);
        send_frame(0);
        set_geometry(1, 1, 0);
        send_frame(0);
    endtask

    task automatic test_frame_wrap();
        set_geometry(3, 2, 9);
        send_frame(0);
        send_frame(1);
    endtask

    // Part of a row at an oversized padded width, then a narrower geometry mid-frame:
    // the column counter is past the new width and restarts at zero.
    task automatic test_wide_reconfig();
        no_gaps = 1'b1;
        set_geometry(2044, 1, 4095);
        for (int i = 0; i < PARTIAL_PIXELS; i++)
            send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        set_geometry(3, 2, 9);
        send_frame(0);
        no_gaps = 1'b0;
    endtask

    // The receiver stalls for a long stretch so the queue fills and pixel_ready drops.
    task automatic test_output_stall();
        set_geometry(6, 3, 10);
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
        send_frame(0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        int ow;
        int start;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            ow = $urandom_range(1, 8);
            set_geometry(ow, $urandom_range(1, 5), ow + 4 + $urandom_range(0, 3));
            no_gaps = ($urandom_range(0, 3) == 0);
            send_frame($urandom_range(0, 1));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OUT_WIDTH;
        cfg_data = '0;
        pixel_valid = 1'b0;
        pixel_c0 = '0;
        pixel_c1 = '0;
        pixel_c2 = '0;
        med_ready = 1'b0;
        error_count = 0;
        pixels_sent = 0;
        med_wait = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        long_hold_req = 1'b0;
        col_pos = 0;
        row_pos = 0;
        m_out_width = OUT_WIDTH_RST;
        m_out_height = OUT_HEIGHT_RST;
        m_padded_width = PADDED_WIDTH_RST;
        for (int k = 0; k < LB_ROWS; k++)
            for (int c = 0; c < MAX_PW; c++)
                line_mem[k][c] = '0;
        win_mem = '{default: '0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_output();
        test_narrow_padding();
        test_empty_frames();
        test_frame_wrap();
        test_output_stall();
        test_wide_reconfig();
        test_random_frames();

        wait_idle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ files.f @@
design/rmf_pkg.sv
design/rmf_ram.sv
design/rmf_front.sv
design/rmf_queue.sv
design/rmf_median.sv
design/rgb_median_filter_5x5.sv
sim/tb_rgb_median_filter_5x5.sv
